// File: src/tsbw_pkg.sv
// ----------------------------------------------------------------------------
// tsbw_pkg
// Shared constants and controller/datapath handshake types for the text
// screen byte writer.
// ----------------------------------------------------------------------------
package tsbw_pkg;

	// payload field widths
	localparam int BYTE_W     = 8;
	localparam int ROW_W      = 6;
	localparam int COL_W      = 7;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_COLS_W = 8;
	localparam int CFG_ROWS_W = 7;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 4'd1;

	// register reset values
	localparam logic [CFG_COLS_W-1:0] COLS_RST = 8'd57;
	localparam logic [CFG_ROWS_W-1:0] ROWS_RST = 7'd42;

	// control bytes
	localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CH_DEL = 8'h7F;

	typedef struct packed {
		logic clr_wr;      // clearing pass: zero one cell
		logic take;        // latch the request, start a cell read if needed
		logic exec;        // apply a feed byte to cursor and cells
		logic scr_start;   // reset the scroll counters
		logic copy_rd;     // read the next source cell of the row copy
		logic clr_row_wr;  // zero one cell of the bottom row
		logic load_out;    // load the result register
	} tsbw_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic op_read;
		logic scroll_need;
		logic copy_last;
		logic clr_last;
		logic rows_one;
	} tsbw_sts_t;

endpackage

// File: src/tsbw_ifs.sv
// ----------------------------------------------------------------------------
// tsbw channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tsbw_req_if;
	import tsbw_pkg::*;

	logic              valid;
	logic              ready;
	logic              op;
	logic [BYTE_W-1:0] data_byte;
	logic [ROW_W-1:0]  read_row;
	logic [COL_W-1:0]  read_col;

	modport source (output valid, op, data_byte, read_row, read_col, input ready);
	modport sink   (input valid, op, data_byte, read_row, read_col, output ready);
endinterface

interface tsbw_rsp_if;
	import tsbw_pkg::*;

	logic              valid;
	logic              ready;
	logic [COL_W-1:0]  cursor_col;
	logic [ROW_W-1:0]  cursor_row;
	logic [BYTE_W-1:0] cell_char;
	logic              scrolled;

	modport source (output valid, cursor_col, cursor_row, cell_char, scrolled, input ready);
	modport sink   (input valid, cursor_col, cursor_row, cell_char, scrolled, output ready);
endinterface

interface tsbw_cfg_if;
	import tsbw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// File: src/tsbw_ram.sv
// ----------------------------------------------------------------------------
// tsbw_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tsbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: src/tsbw_datapath.sv
// ----------------------------------------------------------------------------
// tsbw_datapath
// Geometry registers, cursor, screen memory with its write/read muxing,
// scroll and clearing counters, and the result register.
// ----------------------------------------------------------------------------
module tsbw_datapath #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tsbw_pkg::tsbw_cmd_t                cmd,
	output tsbw_pkg::tsbw_sts_t                sts,
	input  logic                               in_op,
	input  logic [tsbw_pkg::BYTE_W-1:0]        in_byte,
	input  logic [tsbw_pkg::ROW_W-1:0]         in_row,
	input  logic [tsbw_pkg::COL_W-1:0]         in_col,
	input  logic                               cfg_we,
	input  logic [tsbw_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [tsbw_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output logic [tsbw_pkg::COL_W-1:0]         out_col,
	output logic [tsbw_pkg::ROW_W-1:0]         out_row,
	output logic [tsbw_pkg::BYTE_W-1:0]        out_cell,
	output logic                               out_scr
);
	import tsbw_pkg::*;

	localparam int CW    = $clog2(MAX_COLUMNS);
	localparam int RW    = $clog2(MAX_ROWS);
	localparam int AW    = CW + RW;
	localparam int DEPTH = 1 << AW;

	logic [CFG_COLS_W-1:0] cols_q, cols_raw;
	logic [CFG_ROWS_W-1:0] rows_q, rows_raw;
	logic [CW:0]           cols_eff;
	logic [RW:0]           rows_eff;

	logic [CW-1:0]     col_q, col_n, col_d;
	logic [RW-1:0]     line_q, line_d, line_fin;
	logic [RW:0]       line_n;
	logic [CW:0]       col_inc;
	logic              wrap_q, wrap_n;

	logic              op_q, inrng_q, scr_flag_q;
	logic [BYTE_W-1:0] byte_q;

	logic              exec_we;
	logic [AW-1:0]     exec_waddr;
	logic [BYTE_W-1:0] exec_wdata;
	logic              scroll_need;

	logic [RW-1:0]     scr_row_q, prow_s1, bot_row;
	logic [CW-1:0]     scr_col_q, pcol_s1;
	logic              pend_s1;
	logic [AW-1:0]     clr_cnt_q;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [BYTE_W-1:0] ram_wdata, ram_rdata;

	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [BYTE_W-1:0] out_cell_q;
	logic              out_scr_q;

	// geometry in effect, including a write landing this cycle
	always_comb begin
		cols_raw = (cfg_we && cfg_idx == REG_COLS) ? cfg_wdata : cols_q;
		rows_raw = (cfg_we && cfg_idx == REG_ROWS) ? cfg_wdata[CFG_ROWS_W-1:0] : rows_q;
		if (cols_raw == '0) begin
			cols_eff = (CW+1)'(1);
		end else if (16'(cols_raw) > 16'(MAX_COLUMNS)) begin
			cols_eff = (CW+1)'(MAX_COLUMNS);
		end else begin
			cols_eff = (CW+1)'(cols_raw);
		end
		if (rows_raw == '0) begin
			rows_eff = (RW+1)'(1);
		end else if (16'(rows_raw) > 16'(MAX_ROWS)) begin
			rows_eff = (RW+1)'(MAX_ROWS);
		end else begin
			rows_eff = (RW+1)'(rows_raw);
		end
	end

	assign bot_row = RW'(rows_eff - 1'b1);

	// feed byte: next cursor and the cell it touches
	always_comb begin
		col_n      = col_q;
		line_n     = {1'b0, line_q};
		wrap_n     = wrap_q;
		exec_we    = 1'b0;
		exec_waddr = {line_q, col_q};
		exec_wdata = byte_q;
		col_inc    = {1'b0, col_q} + 1'b1;
		case (byte_q)
			CH_CR: begin
				col_n = '0;
			end
			CH_LF: begin
				if (!wrap_q) begin
					line_n = {1'b0, line_q} + 1'b1;
				end
				wrap_n = 1'b0;
			end
			CH_BS, CH_DEL: begin
				if (col_q != '0) begin
					col_n      = col_q - 1'b1;
					exec_we    = 1'b1;
					exec_waddr = {line_q, col_q - 1'b1};
					exec_wdata = '0;
				end
			end
			default: begin
				exec_we = 1'b1;
				if (16'(col_inc) >= 16'(cols_eff)) begin
					col_n  = '0;
					line_n = {1'b0, line_q} + 1'b1;
					wrap_n = 1'b1;
				end else begin
					col_n  = col_inc[CW-1:0];
					wrap_n = 1'b0;
				end
			end
		endcase
		scroll_need = !op_q && (16'(line_n) >= 16'(rows_eff));
		line_fin    = scroll_need ? bot_row : line_n[RW-1:0];
		col_d       = cmd.exec ? col_n : col_q;
		line_d      = cmd.exec ? line_fin : line_q;
	end

	// memory port muxing, one writer per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		if (cmd.clr_wr) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
		end else if (pend_s1) begin
			ram_we    = 1'b1;
			ram_waddr = {prow_s1, pcol_s1};
			ram_wdata = ram_rdata;
		end else if (cmd.clr_row_wr) begin
			ram_we    = 1'b1;
			ram_waddr = {bot_row, scr_col_q};
		end else if (cmd.exec && exec_we) begin
			ram_we    = 1'b1;
			ram_waddr = exec_waddr;
			ram_wdata = exec_wdata;
		end
		ram_re    = (cmd.take && in_op) || cmd.copy_rd;
		ram_raddr = cmd.copy_rd ? {scr_row_q + 1'b1, scr_col_q} : {RW'(in_row), CW'(in_col)};
	end

	tsbw_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_screen_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q     <= COLS_RST;
			rows_q     <= ROWS_RST;
			col_q      <= '0;
			line_q     <= '0;
			wrap_q     <= 1'b0;
			clr_cnt_q  <= '0;
			pend_s1    <= 1'b0;
			scr_row_q  <= '0;
			scr_col_q  <= '0;
			scr_flag_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cols_q <= cols_raw;
				rows_q <= rows_raw;
				// keep the cursor inside the new grid
				if (16'(col_q) >= 16'(cols_eff)) begin
					col_q <= CW'(cols_eff - 1'b1);
				end
				if (16'(line_q) >= 16'(rows_eff)) begin
					line_q <= bot_row;
				end
			end else if (cmd.exec) begin
				col_q  <= col_n;
				line_q <= line_fin;
				wrap_q <= wrap_n;
			end

			if (cmd.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end

			if (cmd.scr_start) begin
				scr_row_q <= '0;
				scr_col_q <= '0;
			end else if (cmd.copy_rd) begin
				if (16'(scr_col_q) == 16'(cols_eff) - 16'd1) begin
					scr_col_q <= '0;
					scr_row_q <= scr_row_q + 1'b1;
				end else begin
					scr_col_q <= scr_col_q + 1'b1;
				end
			end else if (cmd.clr_row_wr) begin
				scr_col_q <= scr_col_q + 1'b1;
			end

			pend_s1 <= cmd.copy_rd;

			if (cmd.take) begin
				scr_flag_q <= 1'b0;
			end else if (cmd.exec) begin
				scr_flag_q <= scroll_need;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		prow_s1 <= scr_row_q;
		pcol_s1 <= scr_col_q;
		if (cmd.take) begin
			op_q    <= in_op;
			byte_q  <= in_byte;
			inrng_q <= (16'(in_row) < 16'(rows_eff)) && (16'(in_col) < 16'(cols_eff));
		end
		if (cmd.load_out) begin
			out_col_q  <= COL_W'(col_d);
			out_row_q  <= ROW_W'(line_d);
			out_cell_q <= (op_q && inrng_q) ? ram_rdata : '0;
			out_scr_q  <= cmd.exec ? scroll_need : scr_flag_q;
		end
	end

	assign sts.clr_done    = &clr_cnt_q;
	assign sts.op_read     = op_q;
	assign sts.scroll_need = scroll_need;
	assign sts.copy_last   = (16'(scr_row_q) == 16'(rows_eff) - 16'd2)
		&& (16'(scr_col_q) == 16'(cols_eff) - 16'd1);
	assign sts.clr_last    = 16'(scr_col_q) == 16'(cols_eff) - 16'd1;
	assign sts.rows_one    = rows_eff == (RW+1)'(1);

	assign out_col  = out_col_q;
	assign out_row  = out_row_q;
	assign out_cell = out_cell_q;
	assign out_scr  = out_scr_q;
endmodule

// File: src/tsbw_ctrl.sv
// ----------------------------------------------------------------------------
// tsbw_ctrl
// Sequencer: clearing pass, request intake, execute, row copy and bottom
// row clear for a scroll, and the result valid flag.
// ----------------------------------------------------------------------------
module tsbw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output tsbw_pkg::tsbw_cmd_t cmd,
	input  tsbw_pkg::tsbw_sts_t sts
);
	import tsbw_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_COPY,
		S_DRAIN,
		S_ZERO
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.take = in_valid;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the result register can take this result
				if (out_free) begin
					if (sts.op_read) begin
						cmd.load_out = 1'b1;
						state_d      = S_IDLE;
					end else begin
						cmd.exec = 1'b1;
						if (sts.scroll_need) begin
							cmd.scr_start = 1'b1;
							state_d       = sts.rows_one ? S_ZERO : S_COPY;
						end else begin
							cmd.load_out = 1'b1;
							state_d      = S_IDLE;
						end
					end
				end
			end
			S_COPY: begin
				cmd.copy_rd = 1'b1;
				if (sts.copy_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// last copied cell is written back here
				state_d = S_ZERO;
			end
			S_ZERO: begin
				cmd.clr_row_wr = 1'b1;
				if (sts.clr_last) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
endmodule

// File: src/text_screen_byte_writer_top.sv
// ----------------------------------------------------------------------------
// text_screen_byte_writer_top
// Dumb-terminal character grid: feed bytes move the cursor and write cells,
// read requests return one cell.
// ----------------------------------------------------------------------------
// One request at a time. A read or a byte that does not scroll passes through
// the intake state that accepts the request and the execute state that loads
// the result register; the next request can be accepted once the block is
// back in idle. The execute state waits while the result register still
// holds an untaken result.
// A scroll adds a row copy of (rows-1)*cols cells through the screen memory,
// a drain state when rows > 1, and a clear of the cols cells of the
// bottom row (rows, cols as in effect). After reset a clearing pass zeroes
// 2**(clog2(MAX_ROWS)+clog2(MAX_COLUMNS)) cells, one a cycle, before the
// first request is accepted; register writes are taken at any time.
module text_screen_byte_writer_top #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 64
) (
	input logic       clk,
	input logic       arst_n,
	tsbw_req_if.sink  req,
	tsbw_rsp_if.source rsp,
	tsbw_cfg_if.sink  cfg
);
	import tsbw_pkg::*;

	tsbw_cmd_t cmd;
	tsbw_sts_t sts;

	assign cfg.ready = 1'b1;

	tsbw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	tsbw_datapath #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_op    (req.op),
		.in_byte  (req.data_byte),
		.in_row   (req.read_row),
		.in_col   (req.read_col),
		.cfg_we   (cfg.valid),
		.cfg_idx  (cfg.index),
		.cfg_wdata(cfg.data),
		.out_col  (rsp.cursor_col),
		.out_row  (rsp.cursor_row),
		.out_cell (rsp.cell_char),
		.out_scr  (rsp.scrolled)
	);
endmodule

// File: tb/tsbw_tb_pkg.sv
// ----------------------------------------------------------------------------
// tsbw_tb_pkg
// Request codes and the response record that the text screen byte writer
// testbench shares between its stimulus and its checker.
// ----------------------------------------------------------------------------
package tsbw_tb_pkg;
	import tsbw_pkg::*;

	typedef enum logic {
		OP_FEED = 1'b0,
		OP_READ = 1'b1
	} tsbw_op_e;

	typedef struct packed {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [BYTE_W-1:0] cell_char;
		logic              scrolled;
	} screen_result_t;

endpackage

// File: tb/tsbw_checker.sv
// ----------------------------------------------------------------------------
// tsbw_checker
// Watches the request, response and register channels of the text screen
// byte writer, keeps its own copy of the grid, cursor and geometry, and
// compares every response with the oldest predicted one.
// ----------------------------------------------------------------------------
module tsbw_checker #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_ROWS    = 64
) (
	input  logic clk,
	input  logic arst_n,
	tsbw_req_if  req,
	tsbw_rsp_if  rsp,
	tsbw_cfg_if  cfg,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import tsbw_pkg::*;
	import tsbw_tb_pkg::*;

	logic [BYTE_W-1:0]     grid [MAX_ROWS][MAX_COLUMNS];
	int                    cur_col;
	int                    cur_row;
	bit                    wrap_mark;
	logic [CFG_COLS_W-1:0] cols_reg;
	logic [CFG_ROWS_W-1:0] rows_reg;
	screen_result_t        pending_results[$];

	function automatic int grid_cols();
		int c;
		c = int'(cols_reg);
		if (c == 0) c = 1;
		if (c > MAX_COLUMNS) c = MAX_COLUMNS;
		return c;
	endfunction

	function automatic int grid_rows();
		int r;
		r = int'(rows_reg);
		if (r == 0) r = 1;
		if (r > MAX_ROWS) r = MAX_ROWS;
		return r;
	endfunction

	function automatic void clamp_cursor();
		if (cur_col >= grid_cols()) cur_col = grid_cols() - 1;
		if (cur_row >= grid_rows()) cur_row = grid_rows() - 1;
	endfunction

	function automatic void clear_screen();
		foreach (grid[r, c]) grid[r][c] = '0;
		cur_col   = 0;
		cur_row   = 0;
		wrap_mark = 1'b0;
		cols_reg  = COLS_RST;
		rows_reg  = ROWS_RST;
		pending_results.delete();
	endfunction

	function automatic void write_geometry(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_COLS: cols_reg = data;
			REG_ROWS: rows_reg = data[CFG_ROWS_W-1:0];
			default: ;
		endcase
		clamp_cursor();
	endfunction

	function automatic screen_result_t terminal_step(tsbw_op_e op, logic [BYTE_W-1:0] b,
			logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
		int cols;
		int rows;
		screen_result_t res;
		cols = grid_cols();
		rows = grid_rows();
		res  = '0;
		clamp_cursor();
		if (op == OP_READ) begin
			if (rr < rows && rc < cols) res.cell_char = grid[rr][rc];
		end else begin
			case (b)
				CH_CR: cur_col = 0;
				CH_LF: begin
					if (!wrap_mark) cur_row++;
					wrap_mark = 1'b0;
				end
				CH_BS, CH_DEL: begin
					// nothing to erase at the left margin
					if (cur_col > 0) begin
						cur_col--;
						grid[cur_row][cur_col] = '0;
					end
				end
				default: begin
					grid[cur_row][cur_col] = b;
					cur_col++;
					if (cur_col >= cols) begin
						cur_col   = 0;
						cur_row++;
						wrap_mark = 1'b1;
					end else begin
						wrap_mark = 1'b0;
					end
				end
			endcase
			if (cur_row >= rows) begin
				// only the columns in use move up and get cleared
				for (int r = 0; r + 1 < rows; r++)
					for (int c = 0; c < cols; c++)
						grid[r][c] = grid[r+1][c];
				for (int c = 0; c < cols; c++)
					grid[rows-1][c] = '0;
				cur_row      = rows - 1;
				res.scrolled = 1'b1;
			end
		end
		res.cursor_col = COL_W'(cur_col);
		res.cursor_row = ROW_W'(cur_row);
		return res;
	endfunction

	function automatic void check_field(string name, logic [BYTE_W-1:0] exp_val,
			logic [BYTE_W-1:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		screen_result_t exp_res;
		if (!arst_n) begin
			clear_screen();
		end else begin
			if (cfg.valid && cfg.ready)
				write_geometry(cfg.index, cfg.data);
			if (req.valid && req.ready)
				pending_results.push_back(terminal_step(tsbw_op_e'(req.op), req.data_byte,
					req.read_row, req.read_col));
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					$error("response with no request waiting: col %0d row %0d char %0d",
						rsp.cursor_col, rsp.cursor_row, rsp.cell_char);
					mismatches++;
				end else begin
					exp_res = pending_results.pop_front();
					check_field("cursor_col", BYTE_W'(exp_res.cursor_col),
						BYTE_W'(rsp.cursor_col));
					check_field("cursor_row", BYTE_W'(exp_res.cursor_row),
						BYTE_W'(rsp.cursor_row));
					check_field("cell_char", exp_res.cell_char, rsp.cell_char);
					check_field("scrolled", BYTE_W'(exp_res.scrolled), BYTE_W'(rsp.scrolled));
				end
			end
		end
		outstanding = pending_results.size();
	end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the text screen byte writer with directed control-byte and
// out-of-range cases, then random byte streams and cell reads over many grid
// geometries, with random stalls on both channels. The checker beside the
// block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tsbw_pkg::*;
	import tsbw_tb_pkg::*;

	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 64;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   src_idle_pct;
	int   sink_idle_pct;
	int   cols_now;
	int   rows_now;

	tsbw_req_if req ();
	tsbw_rsp_if rsp ();
	tsbw_cfg_if cfg ();

	text_screen_byte_writer_top #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cfg   (cfg)
	);

	tsbw_checker #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS   (MAX_ROWS)
	) i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always #5 clk = ~clk;

	initial begin
		#5ms;
		$display("tb_top: FAIL");
		$finish;
	end

	// response side back-pressure
	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready = ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_request(tsbw_op_e op, logic [BYTE_W-1:0] b, logic [ROW_W-1:0] rr,
			logic [COL_W-1:0] rc);
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid = 1'b0;
			@(negedge clk);
		end
		req.valid     = 1'b1;
		req.op        = op;
		req.data_byte = b;
		req.read_row  = rr;
		req.read_col  = rc;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
	endtask

	task automatic feed(logic [BYTE_W-1:0] b);
		send_request(OP_FEED, b, ROW_W'($urandom), COL_W'($urandom));
	endtask

	task automatic read_cell(logic [ROW_W-1:0] rr, logic [COL_W-1:0] rc);
		send_request(OP_READ, BYTE_W'($urandom), rr, rc);
	endtask

	task automatic wait_drained();
		req.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data  = data;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// registers change only with no request in flight
	task automatic set_geometry(int cols, int rows);
		wait_drained();
		write_register(REG_COLS, CFG_DATA_W'(cols));
		// bit 7 of the row write lies outside the register
		write_register(REG_ROWS, {1'($urandom), CFG_ROWS_W'(rows)});
		cols_now = (cols == 0) ? 1 : ((cols > MAX_COLUMNS) ? MAX_COLUMNS : cols);
		rows_now = (rows == 0) ? 1 : ((rows > MAX_ROWS) ? MAX_ROWS : rows);
	endtask

	task automatic random_request();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25) begin
			if ($urandom_range(3) != 0)
				read_cell(ROW_W'($urandom_range(rows_now - 1)),
					COL_W'($urandom_range(cols_now - 1)));
			else
				read_cell(ROW_W'($urandom), COL_W'($urandom));
		end else if (pick < 37) feed(CH_LF);
		else if (pick < 44) feed(CH_CR);
		else if (pick < 50) feed(CH_BS);
		else if (pick < 54) feed(CH_DEL);
		else feed(BYTE_W'($urandom_range(255)));
	endtask

	// big grids come right after short ones so that no scroll copies the whole grid
	task automatic pick_geometry(int k, output int cols, output int rows, output int items);
		items = 22;
		cols  = $urandom_range(16);
		rows  = $urandom_range(8);
		case (k)
			1:  begin cols = 1;   rows = 64;  end
			2:  begin cols = 0;   rows = 0;   end
			3:  begin cols = 128; rows = 64;  items = 20; end
			5:  begin cols = 128; rows = 1;   end
			8:  begin cols = 255; rows = 127; items = 20; end
			10: begin cols = 1;   rows = 1;   end
			12: begin cols = 200; rows = 3;   end
			15: begin cols = 1;   rows = 0;   end
			17: begin cols = 128; rows = 64;  items = 20; end
			19: begin cols = 0;   rows = 127; end
			default: ;
		endcase
	endtask

	initial begin
		int cols;
		int rows;
		int items;
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.op        = OP_FEED;
		req.data_byte = '0;
		req.read_row  = '0;
		req.read_col  = '0;
		cfg.valid     = 1'b0;
		cfg.index     = REG_COLS;
		cfg.data      = '0;
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		cols_now      = COLS_RST;
		rows_now      = ROWS_RST;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// control bytes at the reset geometry
		read_cell(0, 0);
		feed(8'h41);
		feed(8'h00);
		feed(8'hFF);
		feed(CH_BS);
		feed(CH_DEL);
		feed(CH_BS);
		feed(CH_BS);
		feed(CH_CR);
		feed(CH_LF);
		read_cell(0, 0);
		read_cell(41, 56);
		read_cell(42, 0);
		read_cell(0, 57);
		read_cell(63, 127);

		// wrap into a scroll, then line feeds right after the wrap
		set_geometry(4, 2);
		feed(8'h61);
		feed(8'h62);
		feed(8'h63);
		feed(8'h64);
		feed(CH_LF);
		feed(CH_LF);
		read_cell(0, 0);
		read_cell(1, 3);

		// values above the maximum act as the maximum
		set_geometry(255, 127);
		read_cell(63, 127);
		feed(8'h7E);
		feed(CH_LF);

		// sender sparse stalls, receiver heavy; then swapped; then none
		for (int seg = 0; seg < 3; seg++) begin
			src_idle_pct  = (seg == 0) ? 8 : ((seg == 1) ? 77 : 0);
			sink_idle_pct = (seg == 0) ? 77 : ((seg == 1) ? 8 : 0);
			for (int ph = 0; ph < 7; ph++) begin
				pick_geometry(seg * 7 + ph, cols, rows, items);
				set_geometry(cols, rows);
				repeat (items) random_request();
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
